// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the LRU replacement RTL.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== rtl/lru_pkg.sv =====
// Shared constants, types and helpers for the LRU page replacement unit.
// No dependencies.
package lru_pkg;

	localparam int MAX_FRAMES   = 8;
	localparam int PAGE_BITS    = 16;
	localparam int SLOT_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int RANK_W       = SLOT_W;
	localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
	localparam int FAULT_W      = 32;
	localparam int CFG_W        = 4;
	localparam int IN_PAGE_W    = 16;
	localparam int OUT_SLOT_W   = 3;
	localparam int OUT_PAGE_W   = 16;
	localparam int FRAMES_RESET = (MAX_FRAMES < 8) ? MAX_FRAMES : 8;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [FAULT_W-1:0]   fault_t;

	localparam fault_t FAULT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} seq_state_t;

	// one frame as seen through the scan read port
	typedef struct packed {
		logic  valid;
		page_t page;
		rank_t rank;
	} frame_rd_t;

	// end-of-reference update command to the frame table
	typedef struct packed {
		logic  en;
		logic  promote;    // age out ranks above old_rank
		logic  load_page;  // write page into slot (fill or replace)
		slot_t slot;
		rank_t old_rank;
		rank_t new_rank;
		page_t page;
	} frame_wr_t;

	typedef struct packed {
		logic   was_fault;
		slot_t  slot;
		logic   evicted_valid;
		page_t  evicted_page;
		fault_t fault_count;
	} result_t;

	// zero acts as one, anything above the built size acts as the built size
	function automatic cnt_t clamp_frames(logic [CFG_W-1:0] v);
		if (v == '0)
			return cnt_t'(1);
		if (int'(v) > MAX_FRAMES)
			return cnt_t'(MAX_FRAMES);
		return cnt_t'(v);
	endfunction

endpackage

// ===== rtl/lru_frame_table.sv =====
// Frame table: page number, valid bit and recency rank per frame.
// Depends on lru_pkg. One scan read port, one update command per reference.
module lru_frame_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	input  lru_pkg::slot_t     rd_idx,
	output lru_pkg::frame_rd_t rd,
	input  lru_pkg::frame_wr_t wr
);

	logic [lru_pkg::MAX_FRAMES-1:0] valid_q;
	lru_pkg::page_t                 page_q [lru_pkg::MAX_FRAMES];
	lru_pkg::rank_t                 rank_q [lru_pkg::MAX_FRAMES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (flush) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.load_page) begin
			page_q[wr.slot] <= wr.page;
		end
	end

	// rank update in parallel: on promote, ranks above the old one move down
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int i = 0; i < lru_pkg::MAX_FRAMES; i++) begin
				if (lru_pkg::slot_t'(i) == wr.slot) begin
					rank_q[i] <= wr.new_rank;
				end else if (wr.promote && valid_q[i] && (rank_q[i] > wr.old_rank)) begin
					rank_q[i] <= rank_q[i] - lru_pkg::rank_t'(1);
				end
			end
		end
	end

	always_comb begin
		rd.valid = valid_q[rd_idx];
		rd.page  = page_q[rd_idx];
		rd.rank  = rank_q[rd_idx];
	end

endmodule

// ===== rtl/lru_seq.sv =====
// Reference sequencer: walks the frames one per cycle through a shared
// page/rank compare unit, then issues the table update. Depends on lru_pkg.
`include "assert_macros.svh"

module lru_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lru_pkg::page_t     page_in,
	input  lru_pkg::cnt_t      frames,
	output logic               idle,
	output lru_pkg::slot_t     rd_idx,
	input  lru_pkg::frame_rd_t rd,
	output lru_pkg::frame_wr_t wr,
	input  logic               out_free,
	output logic               emit,
	output lru_pkg::result_t   res
);

	lru_pkg::seq_state_t state_q, state_d;

	lru_pkg::slot_t  idx_q;
	lru_pkg::page_t  page_q;
	lru_pkg::cnt_t   vcount_q;
	logic            hit_q;
	lru_pkg::slot_t  hit_slot_q;
	lru_pkg::rank_t  hit_rank_q;
	logic            empty_q;
	lru_pkg::slot_t  empty_slot_q;
	lru_pkg::rank_t  min_rank_q;
	lru_pkg::slot_t  min_slot_q;
	lru_pkg::page_t  min_page_q;
	lru_pkg::fault_t fault_q;
	lru_pkg::result_t res_q;

	// shared compare unit
	logic page_eq, rank_lt, last_frame;
	assign page_eq    = (rd.page == page_q);
	assign rank_lt    = (idx_q == '0) || (rd.rank < min_rank_q);
	assign last_frame = (lru_pkg::cnt_t'(idx_q) == (frames - lru_pkg::cnt_t'(1)));

	// decision at the end of the walk
	logic            replace;
	lru_pkg::slot_t  slot_sel;
	lru_pkg::fault_t fault_next;
	assign replace    = !hit_q && !empty_q;
	assign slot_sel   = hit_q ? hit_slot_q : (empty_q ? empty_slot_q : min_slot_q);
	assign fault_next = (!hit_q && (fault_q != lru_pkg::FAULT_MAX)) ?
		fault_q + lru_pkg::fault_t'(1) : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
			fault_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lru_pkg::ST_UPDATE) begin
				fault_q <= fault_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lru_pkg::ST_IDLE: begin
				if (start) begin
					page_q   <= page_in;
					idx_q    <= '0;
					vcount_q <= '0;
					hit_q    <= 1'b0;
					empty_q  <= 1'b0;
				end
			end
			lru_pkg::ST_SCAN: begin
				if (rd.valid) begin
					vcount_q <= vcount_q + lru_pkg::cnt_t'(1);
					if (!hit_q && page_eq) begin
						hit_q      <= 1'b1;
						hit_slot_q <= idx_q;
						hit_rank_q <= rd.rank;
					end
				end else if (!empty_q) begin
					empty_q      <= 1'b1;
					empty_slot_q <= idx_q;
				end
				if (rank_lt) begin
					min_rank_q <= rd.rank;
					min_slot_q <= idx_q;
					min_page_q <= rd.page;
				end
				idx_q <= idx_q + lru_pkg::slot_t'(1);
			end
			lru_pkg::ST_UPDATE: begin
				res_q.was_fault     <= !hit_q;
				res_q.slot          <= slot_sel;
				res_q.evicted_valid <= replace;
				res_q.evicted_page  <= replace ? min_page_q : '0;
				res_q.fault_count   <= fault_next;
			end
			lru_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		wr          = '0;
		wr.slot     = slot_sel;
		wr.page     = page_q;
		wr.old_rank = hit_q ? hit_rank_q : min_rank_q;
		if (hit_q)
			wr.new_rank = lru_pkg::rank_t'(vcount_q - lru_pkg::cnt_t'(1));
		else if (empty_q)
			wr.new_rank = lru_pkg::rank_t'(vcount_q);
		else
			wr.new_rank = lru_pkg::rank_t'(frames - lru_pkg::cnt_t'(1));
		emit = 1'b0;
		unique case (state_q)
			lru_pkg::ST_IDLE: begin
				if (start)
					state_d = lru_pkg::ST_SCAN;
			end
			lru_pkg::ST_SCAN: begin
				if (last_frame)
					state_d = lru_pkg::ST_UPDATE;
			end
			lru_pkg::ST_UPDATE: begin
				wr.en        = 1'b1;
				wr.promote   = hit_q || replace;
				wr.load_page = !hit_q;
				state_d      = lru_pkg::ST_DONE;
			end
			lru_pkg::ST_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = lru_pkg::ST_IDLE;
				end
			end
			default: state_d = lru_pkg::ST_IDLE;
		endcase
	end

	assign idle   = (state_q == lru_pkg::ST_IDLE);
	assign rd_idx = idx_q;
	assign res    = res_q;

	`ASSERT_CLK(a_scan_in_range, (state_q == lru_pkg::ST_SCAN) |-> (lru_pkg::cnt_t'(idx_q) < frames), "scan index past active frames")
	`ASSERT_CLK(a_start_scans, (idle && start) |=> (state_q == lru_pkg::ST_SCAN), "accepted reference did not start a walk")
	`ASSERT_NEVER(a_fault_down, fault_q < $past(fault_q), "fault total decreased")

endmodule

// ===== rtl/lru_page_replacement_unit.sv =====
// Top level of the LRU page replacement unit: stream ports, configuration
// register and result register. Depends on lru_pkg, lru_frame_table, lru_seq.
//
// Usage:
//  - s_* carries one page reference per transaction (s_tdata = page_number).
//  - m_* returns one result per reference: tuser flags the hit/fault kind and
//    whether a valid page was evicted; tdata carries slot, evicted page and
//    the running fault count.
//  - cfg_* writes frames_in_use (0 acts as 1, above 8 acts as 8). A write
//    empties all frames and keeps the fault total. cfg_ready is high only
//    while no reference is in the sequencer and no result is waiting; a
//    pending cfg write holds off s_tready, so the write goes first.
// Flow:
//  - A reference passes from acceptance to the result register through the
//    scan (one frame per cycle through the shared page/rank comparator), the
//    table update and the done state, which waits for the result register.
//  - s_tready is high only while the sequencer is idle, so one reference is
//    in flight at a time; the unit takes no new reference until the last one
//    has left the sequencer and it is back in idle.
//  - The result register parts the two sides: the next reference is taken
//    while a result waits; a stalled m_tready holds the finished result in the
//    sequencer until the register frees.
// Reset: arst_n clears all frames, the fault total and the handshakes, and
// sets frames_in_use to 8.
`include "assert_macros.svh"

module lru_page_replacement_unit (
	input  logic        clk,
	input  logic        arst_n,
	// reference stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] page_number
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [2:0] frame_slot, [18:3] evicted_page,
	                               // [50:19] fault_count, [55:51] zero
	output logic [1:0]  m_tuser,   // [0] was_fault, [1] evicted_valid
	// configuration: frames_in_use
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	lru_pkg::cnt_t      frames_q;
	logic               cfg_wr;
	logic               seq_idle, start, out_free, emit;
	lru_pkg::slot_t     rd_idx;
	lru_pkg::frame_rd_t rd;
	lru_pkg::frame_wr_t wr;
	lru_pkg::result_t   res;
	lru_pkg::result_t   out_q;
	logic               m_tvalid_q;

	// config only lands with nothing in flight
	assign cfg_ready = seq_idle && !m_tvalid_q;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lru_pkg::cnt_t'(lru_pkg::FRAMES_RESET);
		end else if (cfg_wr) begin
			frames_q <= lru_pkg::clamp_frames(cfg_data);
		end
	end

	assign s_tready = seq_idle && !cfg_valid;
	assign start    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	lru_frame_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (cfg_wr),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	lru_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.page_in  (lru_pkg::page_t'(s_tdata)),
		.frames   (frames_q),
		.idle     (seq_idle),
		.rd_idx   (rd_idx),
		.rd       (rd),
		.wr       (wr),
		.out_free (out_free),
		.emit     (emit),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {out_q.evicted_valid, out_q.was_fault};
	assign m_tdata  = {5'd0, out_q.fault_count,
		lru_pkg::OUT_PAGE_W'(out_q.evicted_page), lru_pkg::OUT_SLOT_W'(out_q.slot)};

	`ASSERT_CLK(a_hit_no_evict, (m_tvalid_q && !out_q.was_fault) |-> !out_q.evicted_valid, "hit reported an eviction")
	`ASSERT_CLK(a_slot_in_range, (m_tvalid_q && !cfg_wr) |-> (lru_pkg::cnt_t'(out_q.slot) < frames_q), "result slot beyond active frames")

endmodule

// ===== tb/tb_lru_page_replacement_unit.sv =====
// Self-checking testbench for lru_page_replacement_unit: directed table, then random phases.
// Depends on lru_pkg and the unit's RTL; results are checked against a local LRU predictor.

module tb_lru_page_replacement_unit;
	import lru_pkg::*;

	localparam int RESET_CYCLES  = 8;
	localparam int DRAIN_CYCLES  = 24;      // well past a reference's walk through the unit
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 8;
	localparam int PHASE_REFS    = 150;
	localparam int POOL_MAX      = 16;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = '0;

	lru_page_replacement_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// one line of the directed table: a frame-count write or a page reference,
	// the latter optionally with its result spelled out
	typedef struct packed {
		bit          is_cfg;
		logic [15:0] value;
		bit          typed;
		result_t     want;
	} stim_row_t;

	// local copy of the frame table
	page_t  held_page [MAX_FRAMES];
	bit     held_valid[MAX_FRAMES];
	rank_t  age_rank  [MAX_FRAMES];
	fault_t faults_seen;
	int     active_frames;

	result_t   pending_results[$];
	stim_row_t directed_rows[$];

	int  mismatches     = 0;
	int  refs_checked   = 0;
	int  faults_checked = 0;
	int  evicts_checked = 0;
	int  cfg_writes     = 0;
	int  cycle_count    = 0;
	bit  quiet          = 1'b0;   // no idling on either side
	int  stall_left     = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic void empty_frames();
		int i;
		for (i = 0; i < MAX_FRAMES; i++) begin
			held_page[i]  = '0;
			held_valid[i] = 1'b0;
			age_rank[i]   = '0;
		end
	endfunction

	function automatic void set_frame_count(input logic [3:0] v);
		if (v == 4'd0)
			active_frames = 1;
		else if (int'(v) > MAX_FRAMES)
			active_frames = MAX_FRAMES;
		else
			active_frames = int'(v);
		empty_frames();
	endfunction

	// slot becomes most recent; everyone younger than its old rank ages by one
	function automatic void promote_frame(input int slot, input rank_t old, input int count);
		int i;
		for (i = 0; i < MAX_FRAMES; i++)
			if (i != slot && held_valid[i] && age_rank[i] > old)
				age_rank[i] = age_rank[i] - 1'b1;
		age_rank[slot] = rank_t'(count - 1);
	endfunction

	function automatic result_t predict_reference(input page_t pg);
		result_t r;
		int      i;
		int      used;
		int      slot;
		bit      hit;
		bit      found_empty;
		rank_t   oldest;
		r           = '0;
		used        = 0;
		slot        = 0;
		hit         = 1'b0;
		found_empty = 1'b0;
		for (i = 0; i < active_frames; i++)
			if (held_valid[i]) begin
				used++;
				if (!hit && held_page[i] == pg) begin
					hit  = 1'b1;
					slot = i;
				end
			end
		if (hit) begin
			promote_frame(slot, age_rank[slot], used);
		end else begin
			for (i = 0; i < active_frames; i++)
				if (!found_empty && !held_valid[i]) begin
					found_empty = 1'b1;
					slot        = i;
				end
			if (found_empty) begin
				// fill: new frame joins as the youngest of the valid set
				held_page[slot]  = pg;
				held_valid[slot] = 1'b1;
				age_rank[slot]   = rank_t'(used);
			end else begin
				oldest = age_rank[0];
				slot   = 0;
				for (i = 1; i < active_frames; i++)
					if (age_rank[i] < oldest) begin
						oldest = age_rank[i];
						slot   = i;
					end
				r.evicted_valid = 1'b1;
				r.evicted_page  = held_page[slot];
				held_page[slot] = pg;
				promote_frame(slot, oldest, active_frames);
			end
			if (faults_seen != FAULT_MAX)
				faults_seen = faults_seen + 1'b1;
		end
		r.was_fault   = !hit;
		r.slot        = slot_t'(slot);
		r.fault_count = faults_seen;
		return r;
	endfunction

	// ---------------- directed table ----------------

	function automatic void row_cfg(input logic [3:0] v);
		stim_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.value  = 16'(v);
		directed_rows.push_back(r);
	endfunction

	function automatic void row_ref(input page_t pg);
		stim_row_t r;
		r       = '0;
		r.value = pg;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_ref_known(input page_t pg, input logic flt, input int slot,
			input logic ev, input page_t evp, input int unsigned cnt);
		stim_row_t r;
		r                    = '0;
		r.value              = pg;
		r.typed              = 1'b1;
		r.want.was_fault     = flt;
		r.want.slot          = slot_t'(slot);
		r.want.evicted_valid = ev;
		r.want.evicted_page  = evp;
		r.want.fault_count   = fault_t'(cnt);
		directed_rows.push_back(r);
	endfunction

	function automatic void build_directed_rows();
		int p;
		// out of reset: all 8 frames empty, fault total zero
		row_ref_known(16'h0000, 1'b1, 0, 1'b0, 16'h0000, 1);
		row_ref_known(16'hFFFF, 1'b1, 1, 1'b0, 16'h0000, 2);
		row_ref_known(16'h0000, 1'b0, 0, 1'b0, 16'h0000, 2);
		row_ref_known(16'hFFFF, 1'b0, 1, 1'b0, 16'h0000, 2);
		// zero frames acts as one; the flush keeps the fault total
		row_cfg(4'd0);
		row_ref_known(16'h1234, 1'b1, 0, 1'b0, 16'h0000, 3);
		row_ref_known(16'h1234, 1'b0, 0, 1'b0, 16'h0000, 3);
		row_ref_known(16'hABCD, 1'b1, 0, 1'b1, 16'h1234, 4);
		row_ref_known(16'h1234, 1'b1, 0, 1'b1, 16'hABCD, 5);
		// largest code clamps to the built size: fill all 8, then evict
		row_cfg(4'd15);
		for (p = 1; p <= 9; p++)
			row_ref(page_t'(p));
		row_ref(16'h0002);   // hit refreshes page 2, so page 3 goes next
		row_ref(16'h000A);
		row_cfg(4'd3);
		row_ref(16'h5555);
		row_ref(16'hAAAA);
		row_ref(16'h5555);
		row_ref(16'h7777);
		row_ref(16'h8000);
	endfunction

	// ---------------- drivers ----------------

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("[%0d] mismatch on %s: got 0x%0h, expected 0x%0h",
			cycle_count, what, got, want);
		mismatches++;
	endtask

	// hold the sender until every outstanding result is back and the unit is quiet
	task automatic drain_all();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [3:0] v);
		drain_all();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		set_frame_count(v);
		cfg_writes++;
	endtask

	task automatic send_reference(input page_t pg, input bit typed, input result_t want);
		result_t predicted;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pg;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_reference(pg);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// ---------------- result side ----------------

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result transaction", m_tdata, 0);
			end else begin
				want = pending_results.pop_front();
				refs_checked++;
				if (want.was_fault)
					faults_checked++;
				if (want.evicted_valid)
					evicts_checked++;
				if (m_tuser[0] !== want.was_fault)
					report_mismatch("was_fault", m_tuser[0], want.was_fault);
				if (m_tdata[2:0] !== want.slot)
					report_mismatch("frame_slot", m_tdata[2:0], want.slot);
				if (m_tuser[1] !== want.evicted_valid)
					report_mismatch("evicted_valid", m_tuser[1], want.evicted_valid);
				if (m_tdata[18:3] !== want.evicted_page)
					report_mismatch("evicted_page", m_tdata[18:3], want.evicted_page);
				if (m_tdata[50:19] !== want.fault_count)
					report_mismatch("fault_count", m_tdata[50:19], want.fault_count);
			end
		end
		// random backpressure bursts
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 11);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		logic [3:0] phase_setting[PHASES];
		page_t      hot_pages[POOL_MAX];
		int         pool_size;
		int         phase;
		int         k;
		int         sel;
		page_t      pg;
		stim_row_t  row;

		faults_seen = '0;
		set_frame_count(4'(FRAMES_RESET));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed_rows();
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg)
				write_frame_count(row.value[3:0]);
			else
				send_reference(row.value, row.typed, row.want);
		end

		phase_setting[0] = 4'd8;
		phase_setting[1] = 4'd1;
		phase_setting[2] = 4'd15;
		phase_setting[3] = 4'd5;
		phase_setting[4] = 4'd0;
		phase_setting[5] = 4'($urandom_range(0, 15));
		phase_setting[6] = 4'($urandom_range(2, 7));
		phase_setting[7] = 4'd8;

		for (phase = 0; phase < PHASES; phase++) begin
			quiet = (phase == PHASES - 1);
			write_frame_count(phase_setting[phase]);
			// working set of one up to twice the frames, so hits and evictions mix
			pool_size = $urandom_range(1, 2 * active_frames);
			for (k = 0; k < POOL_MAX; k++)
				hot_pages[k] = page_t'($urandom);
			for (k = 0; k < PHASE_REFS; k++) begin
				if (k == PHASE_REFS / 2 && phase % 3 == 1)
					drain_all();
				sel = $urandom_range(0, 9);
				if (sel < 7)
					pg = hot_pages[$urandom_range(0, pool_size - 1)];
				else if (sel < 9)
					pg = hot_pages[k % pool_size];   // cyclic walk, worst case for LRU
				else
					pg = page_t'($urandom);
				send_reference(pg, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d references (%0d faults, %0d evictions) over %0d frame-count writes",
			refs_checked, faults_checked, evicts_checked, cfg_writes);
		$display("frame counts 0, 1, 8 and 15 included; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lru_pkg.sv
rtl/lru_frame_table.sv
rtl/lru_seq.sv
rtl/lru_page_replacement_unit.sv
tb/tb_lru_page_replacement_unit.sv
